/* rtl/plcs_pkg.sv */
// Shared types, constants and the octant order of the plotter step generator.
package plcs_pkg;

  // Default configuration.
  localparam int COORD_WIDTH_DEF        = 16;
  localparam int MAX_RADIUS_DEF         = 2047;
  localparam int POINT_BUFFER_DEPTH_DEF = 2048;

  // Fixed field widths.
  localparam int RADIUS_W      = 11;
  localparam int POINT_INDEX_W = 11;
  localparam int OP_W          = 2;
  localparam int STEP_W        = 2;

  // Command codes.
  localparam logic [OP_W-1:0] OP_LINE   = 2'd0;
  localparam logic [OP_W-1:0] OP_CIRCLE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Octant numbers with a special role.
  localparam logic [2:0] OCT_FIRST = 3'd0;
  localparam logic [2:0] OCT_LAST  = 3'd7;

  // Controller mode.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_LINE   = 3'b010,
    MODE_CIRCLE = 3'b100
  } mode_t;

  // How one octant maps the walked point onto the circle.
  typedef struct packed {
    logic swap;
    logic mirror_x;
    logic mirror_y;
    logic reversed;
  } octant_t;

  // Fixed mirror and swap order of the eight octants.
  function automatic octant_t octant_cfg(input logic [2:0] idx);
    octant_t oc;
    case (idx)
      3'd0:    oc = '{swap: 1'b1, mirror_x: 1'b0, mirror_y: 1'b1, reversed: 1'b0};
      3'd1:    oc = '{swap: 1'b0, mirror_x: 1'b0, mirror_y: 1'b1, reversed: 1'b1};
      3'd2:    oc = '{swap: 1'b0, mirror_x: 1'b0, mirror_y: 1'b0, reversed: 1'b0};
      3'd3:    oc = '{swap: 1'b1, mirror_x: 1'b0, mirror_y: 1'b0, reversed: 1'b1};
      3'd4:    oc = '{swap: 1'b1, mirror_x: 1'b1, mirror_y: 1'b0, reversed: 1'b0};
      3'd5:    oc = '{swap: 1'b0, mirror_x: 1'b1, mirror_y: 1'b0, reversed: 1'b1};
      3'd6:    oc = '{swap: 1'b0, mirror_x: 1'b1, mirror_y: 1'b1, reversed: 1'b0};
      default: oc = '{swap: 1'b1, mirror_x: 1'b1, mirror_y: 1'b1, reversed: 1'b1};
    endcase
    return oc;
  endfunction

endpackage

/* rtl/plcs_cmd_if.sv */
// Command channel: operation, line target and circle radius.
interface plcs_cmd_if #(
  parameter int COORD_WIDTH = plcs_pkg::COORD_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [plcs_pkg::OP_W-1:0]            operation;
  logic signed [COORD_WIDTH-1:0]        target_x;
  logic signed [COORD_WIDTH-1:0]        target_y;
  logic [plcs_pkg::RADIUS_W-1:0]        radius;

  modport source (output valid, operation, target_x, target_y, radius, input ready);
  modport sink (input valid, operation, target_x, target_y, radius, output ready);
endinterface

/* rtl/plcs_step_if.sv */
// Step channel: per-axis moves, pen position and end-of-command flag.
interface plcs_step_if #(
  parameter int COORD_WIDTH = plcs_pkg::COORD_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [plcs_pkg::STEP_W-1:0]   step_x;
  logic signed [plcs_pkg::STEP_W-1:0]   step_y;
  logic signed [COORD_WIDTH-1:0]        pen_x;
  logic signed [COORD_WIDTH-1:0]        pen_y;
  logic                                 last;

  modport source (output valid, step_x, step_y, pen_x, pen_y, last, input ready);
  modport sink (input valid, step_x, step_y, pen_x, pen_y, last, output ready);
endinterface

/* rtl/plcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module plcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/plotter_line_circle_stepper.sv */
// Plotter step generator: Bresenham lines and midpoint circles from a tracked pen.
//
// Usage. Commands arrive on the cmd channel, one per transaction: operation 0 starts
// a line from the pen to (target_x, target_y), operation 1 starts a circle of the
// given radius around the absolute centre (radius, radius), operation 2 is a tick.
// A tick while a line or circle is running yields exactly one transaction on the
// step channel: a move of -1, 0 or +1 on each axis, the pen position after the move
// and a last flag on the final step. Line and circle commands arriving while a
// command runs are dropped, as are idle ticks and unused operation codes; none of
// these produce a step.
// Timing. Every command is processed in the cycle it is accepted and its step is
// registered, so it appears on the step channel in the cycle after acceptance. One
// command can be accepted every cycle unless the step channel stalls; the pen,
// Bresenham terms and octant walk all update incrementally in the accepting cycle.
// Reversed octants replay the first octant from a point buffer RAM whose read address
// runs one command ahead, so the registered read data is ready when the next tick arrives.
// Stalls. cmd.ready is low only while a step is held and step.ready is low.
// Reset. The pen returns to (0, 0), the block goes idle and any held step is
// dropped; the point buffer needs no clearing.
module plotter_line_circle_stepper #(
  parameter int COORD_WIDTH        = plcs_pkg::COORD_WIDTH_DEF,
  parameter int MAX_RADIUS         = plcs_pkg::MAX_RADIUS_DEF,
  parameter int POINT_BUFFER_DEPTH = plcs_pkg::POINT_BUFFER_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  plcs_cmd_if.sink     cmd,
  plcs_step_if.source  step
);
  import plcs_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int RW  = RADIUS_W;
  localparam int PIW = POINT_INDEX_W;
  // Walk coordinates must hold both a pen coordinate and a mirrored circle point.
  localparam int WW  = ((CW > RW + 2) ? CW : RW + 2) + 1;
  localparam int TW  = WW + 1;
  localparam int DW  = CW + 1;
  localparam int EW  = CW + 2;
  localparam int CDW = RW + 3;
  localparam int AW  = $clog2(POINT_BUFFER_DEPTH);

  localparam logic signed [WW-1:0]  WONE = WW'(1);
  localparam logic signed [CDW-1:0] DONE = CDW'(1);

  // Architectural state.
  mode_t                  mode, mode_next;
  logic signed [CW-1:0]   pen_x, pen_x_next, pen_y, pen_y_next;
  logic signed [CW-1:0]   dest_x, dest_x_next, dest_y, dest_y_next;
  logic signed [EW-1:0]   line_error, line_error_next;
  logic signed [DW-1:0]   line_delta_x, line_delta_x_next, line_delta_y, line_delta_y_next;
  logic signed [WW-1:0]   walk_x, walk_x_next, walk_y, walk_y_next;
  logic [1:0]             dir, dir_next;
  logic signed [CDW-1:0]  decision, decision_next;
  logic [2:0]             octant, octant_next;
  logic [PIW-1:0]         point_index, point_index_next, point_count, point_count_next;
  logic [RW-1:0]          circle_radius, circle_radius_next;

  // Result register.
  logic                   res_valid;
  logic signed [1:0]      res_step_x, res_step_y;
  logic signed [CW-1:0]   res_pen_x, res_pen_y;
  logic                   res_last, res_last_next;
  logic                   produce;

  // Handshake.
  logic accept;
  assign cmd.ready = !res_valid || step.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign step.valid  = res_valid;
  assign step.step_x = res_step_x;
  assign step.step_y = res_step_y;
  assign step.pen_x  = res_pen_x;
  assign step.pen_y  = res_pen_y;
  assign step.last   = res_last;

  // Point buffer and its look-ahead read path.
  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [RW-1:0]        wr_data, ram_rdata, byp_data, buf_val;
  logic [AW+WW-1:0]     wy_ext;
  logic [AW+PIW-1:0]    pi_ext;
  logic                 rd_ok, rd_ok_next, byp_hit, byp_hit_next;

  assign wy_ext     = {{AW{1'b0}}, walk_y};
  assign pi_ext     = {{AW{1'b0}}, point_index_next};
  assign wr_addr    = wy_ext[AW-1:0];
  assign rd_addr    = pi_ext[AW-1:0];
  assign wr_data    = walk_x[RW-1:0];
  assign rd_ok_next = 32'(point_index_next) < 32'(POINT_BUFFER_DEPTH);
  assign byp_hit_next = wr_en && (wr_addr == rd_addr);
  assign buf_val    = !rd_ok ? '0 : (byp_hit ? byp_data : ram_rdata);

  plcs_ram #(
    .WIDTH (RW),
    .DEPTH (POINT_BUFFER_DEPTH)
  ) u_point_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // Circle point of the current octant, mapped about the centre.
  octant_t               cur_oc, nxt_oc;
  logic signed [WW-1:0]  oa, ob, cpx, cpy;
  logic signed [TW-1:0]  r_ext, circ_tx, circ_ty;
  always_comb begin
    cur_oc = octant_cfg(octant);
    if (cur_oc.reversed) begin
      oa = WW'(buf_val);
      ob = WW'(point_index);
    end else begin
      oa = walk_x;
      ob = walk_y;
    end
    cpx = cur_oc.swap ? ob : oa;
    cpy = cur_oc.swap ? oa : ob;
    if (cur_oc.mirror_x) begin
      cpx = -cpx;
    end
    if (cur_oc.mirror_y) begin
      cpy = -cpy;
    end
    r_ext   = TW'(circle_radius);
    circ_tx = TW'(cpx) + r_ext;
    circ_ty = TW'(cpy) + r_ext;
  end

  // One step toward the current path point on each axis.
  logic signed [TW-1:0]  tgt_x, tgt_y, diff_x, diff_y, pen_x_ext, pen_y_ext;
  logic signed [1:0]     sx, sy;
  logic signed [CW-1:0]  pen_x_step, pen_y_step;
  always_comb begin
    tgt_x     = (mode == MODE_LINE) ? TW'(walk_x) : circ_tx;
    tgt_y     = (mode == MODE_LINE) ? TW'(walk_y) : circ_ty;
    pen_x_ext = TW'(pen_x);
    pen_y_ext = TW'(pen_y);
    diff_x    = tgt_x - pen_x_ext;
    diff_y    = tgt_y - pen_y_ext;
    sx = diff_x[TW-1] ? 2'b11 : ((diff_x == '0) ? 2'b00 : 2'b01);
    sy = diff_y[TW-1] ? 2'b11 : ((diff_y == '0) ? 2'b00 : 2'b01);
    pen_x_step = pen_x + CW'(sx);
    pen_y_step = pen_y + CW'(sy);
  end

  // Line set-up terms from the command and the pen.
  logic signed [CW-1:0]  tx_c, ty_c;
  logic signed [DW-1:0]  dx_raw, dy_raw, dx_abs, dy_abs;
  logic [RW-1:0]         r_sat;
  always_comb begin
    tx_c   = CW'(cmd.target_x);
    ty_c   = CW'(cmd.target_y);
    dx_raw = DW'(tx_c) - DW'(pen_x);
    dy_raw = DW'(ty_c) - DW'(pen_y);
    dx_abs = dx_raw[DW-1] ? -dx_raw : dx_raw;
    dy_abs = dy_raw[DW-1] ? -dy_raw : dy_raw;
    r_sat  = (32'(cmd.radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : cmd.radius;
  end

  // Bresenham error update for a line tick.
  logic signed [EW:0]    e2, ndy, pdx;
  logic                  move_x, move_y, line_done;
  always_comb begin
    e2        = {line_error, 1'b0};
    ndy       = -((EW + 1)'(line_delta_y));
    pdx       = (EW + 1)'(line_delta_x);
    move_x    = e2 > ndy;
    move_y    = e2 < pdx;
    line_done = (pen_x_step == dest_x) && (pen_y_step == dest_y);
  end

  // Midpoint decision update for a forward circle tick.
  logic signed [WW-1:0]  wx1, wy1;
  logic signed [CDW-1:0] dec_term;
  logic                  dec_low, oct_end;
  always_comb begin
    dec_low  = decision[CDW-1] || (decision == '0);
    wy1      = walk_y + WONE;
    wx1      = dec_low ? walk_x : walk_x - WONE;
    dec_term = dec_low ? CDW'(wy1) : CDW'(wy1 - wx1);
    oct_end  = cur_oc.reversed ? (point_index == '0) : (wy1 > wx1);
  end

  // Command decode and next state.
  always_comb begin
    mode_next          = mode;
    pen_x_next         = pen_x;
    pen_y_next         = pen_y;
    dest_x_next        = dest_x;
    dest_y_next        = dest_y;
    line_error_next    = line_error;
    line_delta_x_next  = line_delta_x;
    line_delta_y_next  = line_delta_y;
    walk_x_next        = walk_x;
    walk_y_next        = walk_y;
    dir_next           = dir;
    decision_next      = decision;
    octant_next        = octant;
    point_index_next   = point_index;
    point_count_next   = point_count;
    circle_radius_next = circle_radius;
    nxt_oc             = octant_cfg(octant + 3'd1);
    produce            = 1'b0;
    res_last_next      = 1'b0;
    wr_en              = 1'b0;
    if (accept) begin
      case (mode)
        MODE_IDLE: begin
          if (cmd.operation == OP_LINE) begin
            dest_x_next = tx_c;
            dest_y_next = ty_c;
            if (!((tx_c == pen_x) && (ty_c == pen_y))) begin
              line_delta_x_next = dx_abs;
              line_delta_y_next = dy_abs;
              dir_next[0]       = dx_raw[DW-1] || (dx_raw == '0);
              dir_next[1]       = dy_raw[DW-1] || (dy_raw == '0);
              line_error_next   = EW'(dx_abs) - EW'(dy_abs);
              walk_x_next       = WW'(pen_x);
              walk_y_next       = WW'(pen_y);
              mode_next         = MODE_LINE;
            end
          end else if (cmd.operation == OP_CIRCLE) begin
            circle_radius_next = r_sat;
            octant_next        = OCT_FIRST;
            point_index_next   = '0;
            walk_x_next        = WW'(r_sat);
            walk_y_next        = '0;
            decision_next      = DONE - CDW'(r_sat);
            mode_next          = MODE_CIRCLE;
          end
        end
        MODE_LINE: begin
          if (cmd.operation == OP_TICK) begin
            produce         = 1'b1;
            res_last_next   = line_done;
            pen_x_next      = pen_x_step;
            pen_y_next      = pen_y_step;
            line_error_next = line_error - (move_x ? EW'(line_delta_y) : '0)
                                         + (move_y ? EW'(line_delta_x) : '0);
            if (move_x) begin
              walk_x_next = dir[0] ? walk_x - WONE : walk_x + WONE;
            end
            if (move_y) begin
              walk_y_next = dir[1] ? walk_y - WONE : walk_y + WONE;
            end
            if (line_done) begin
              mode_next = MODE_IDLE;
            end
          end
        end
        MODE_CIRCLE: begin
          if (cmd.operation == OP_TICK) begin
            produce       = 1'b1;
            res_last_next = oct_end && (octant == OCT_LAST);
            pen_x_next    = pen_x_step;
            pen_y_next    = pen_y_step;
            if (!cur_oc.reversed) begin
              // The first octant records each x for the reversed replays.
              wr_en = (octant == OCT_FIRST) &&
                      (64'(walk_y) < 64'(POINT_BUFFER_DEPTH));
              walk_y_next   = wy1;
              walk_x_next   = wx1;
              decision_next = decision + (dec_term <<< 1) + DONE;
              if (oct_end && (octant == OCT_FIRST)) begin
                point_count_next = wy1[PIW-1:0];
              end
            end else if (!oct_end) begin
              point_index_next = point_index - PIW'(1);
            end
            if (oct_end) begin
              if (octant == OCT_LAST) begin
                mode_next   = MODE_IDLE;
                octant_next = OCT_FIRST;
              end else begin
                octant_next = octant + 3'd1;
                if (nxt_oc.reversed) begin
                  point_index_next = point_count_next - PIW'(1);
                end else begin
                  walk_x_next   = WW'(circle_radius);
                  walk_y_next   = '0;
                  decision_next = DONE - CDW'(circle_radius);
                end
              end
            end
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      pen_x         <= '0;
      pen_y         <= '0;
      dest_x        <= '0;
      dest_y        <= '0;
      line_error    <= '0;
      line_delta_x  <= '0;
      line_delta_y  <= '0;
      walk_x        <= '0;
      walk_y        <= '0;
      dir           <= '0;
      decision      <= '0;
      octant        <= OCT_FIRST;
      point_index   <= '0;
      point_count   <= '0;
      circle_radius <= '0;
      rd_ok         <= 1'b0;
      byp_hit       <= 1'b0;
    end else begin
      mode          <= mode_next;
      pen_x         <= pen_x_next;
      pen_y         <= pen_y_next;
      dest_x        <= dest_x_next;
      dest_y        <= dest_y_next;
      line_error    <= line_error_next;
      line_delta_x  <= line_delta_x_next;
      line_delta_y  <= line_delta_y_next;
      walk_x        <= walk_x_next;
      walk_y        <= walk_y_next;
      dir           <= dir_next;
      decision      <= decision_next;
      octant        <= octant_next;
      point_index   <= point_index_next;
      point_count   <= point_count_next;
      circle_radius <= circle_radius_next;
      rd_ok         <= rd_ok_next;
      byp_hit       <= byp_hit_next;
    end
  end

  // A write landing on the address being read is forwarded past the RAM.
  always_ff @(posedge clk) begin
    byp_data <= wr_data;
  end

  // Output register: holds a step until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= produce;
    end else if (step.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      res_step_x <= sx;
      res_step_y <= sy;
      res_pen_x  <= pen_x_step;
      res_pen_y  <= pen_y_step;
      res_last   <= res_last_next;
    end
  end

`ifndef ASSERT_OFF
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && produce && res_last_next) |=> (mode == MODE_IDLE))
    else $error("final step did not return the block to idle");

  a_held_pen_matches: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_pen_x == pen_x) && (res_pen_y == pen_y)))
    else $error("held step disagrees with the tracked pen");

  a_replay_in_range: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_CIRCLE) && cur_oc.reversed) |-> (point_index < point_count))
    else $error("reversed octant reads beyond the recorded points");

  a_step_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_step_x != 2'b10) && (res_step_y != 2'b10)))
    else $error("step value outside -1..1");

  a_busy_cmd_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode != MODE_IDLE) && (cmd.operation != OP_TICK))
      |=> (mode == $past(mode)))
    else $error("command accepted while busy changed the mode");
`endif

endmodule
